>>> design/tlbc_pkg.sv
package tlbc_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_W      = 20;
    localparam int SLOT_W      = 4;
    localparam int CFG_W       = 5;
    localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(16);
    // compare width for entry index against the active count
    localparam int CMP_W = ($clog2(TLB_ENTRIES) + 1 > CFG_W) ?
                           $clog2(TLB_ENTRIES) + 1 : CFG_W;

    // carried from each cell to the next along the row
    typedef struct packed {
        logic lead;         // set only into the first cell
        logic hit_seen;     // an earlier active entry matched
        logic inv_seen;     // an earlier active entry is invalid
        logic unused_seen;  // an earlier active entry has its used bit clear
    } tlbc_chain_t;

    // request and row-wide outcome broadcast to every cell
    typedef struct packed {
        logic              update;
        logic              any_hit;
        logic              any_inv;
        logic              any_unused;
        logic              write;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] walk;
    } tlbc_bcast_t;

    // what a cell hands back for the result
    typedef struct packed {
        logic              sel;    // this entry hit or is the refill victim
        logic              hit;
        logic [PAGE_W-1:0] frame;  // stored frame on a hit, zero otherwise
    } tlbc_res_t;

endpackage

>>> design/tlbc_cell.sv
module tlbc_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  active,
    input  tlbc_pkg::tlbc_chain_t chain_in,
    output tlbc_pkg::tlbc_chain_t chain_out,
    input  tlbc_pkg::tlbc_bcast_t bcast,
    output tlbc_pkg::tlbc_res_t   res
);

    logic                        valid_reg, valid_next;
    logic                        used_reg, used_next;
    logic                        dirty_reg, dirty_next;
    logic [tlbc_pkg::PAGE_W-1:0] page_reg;
    logic [tlbc_pkg::PAGE_W-1:0] frame_reg;

    logic match, is_hit, first_inv, first_unused, victim, sweep_clear;

    assign match        = active && valid_reg && (page_reg == bcast.page);
    assign is_hit       = match && !chain_in.hit_seen;
    assign first_inv    = active && !valid_reg && !chain_in.inv_seen;
    assign first_unused = active && !used_reg && !chain_in.unused_seen;

    // victim: first invalid entry, else first unused one, else entry 0
    assign victim = !bcast.any_hit && (bcast.any_inv ? first_inv :
                    (bcast.any_unused ? first_unused : chain_in.lead));
    // sweep clears used bits up to the first unused entry
    assign sweep_clear = !bcast.any_hit && !bcast.any_inv && active &&
                         !chain_in.unused_seen;

    assign chain_out.lead        = 1'b0;
    assign chain_out.hit_seen    = chain_in.hit_seen || match;
    assign chain_out.inv_seen    = chain_in.inv_seen || (active && !valid_reg);
    assign chain_out.unused_seen = chain_in.unused_seen || (active && !used_reg);

    assign res.sel   = is_hit || victim;
    assign res.hit   = is_hit;
    assign res.frame = is_hit ? frame_reg : '0;

    always_comb begin
        valid_next = valid_reg;
        used_next  = used_reg;
        dirty_next = dirty_reg;
        if (bcast.update) begin
            priority if (is_hit) begin
                used_next  = 1'b1;
                dirty_next = dirty_reg || bcast.write;
            end else if (victim) begin
                valid_next = 1'b1;
                used_next  = 1'b1;
                dirty_next = bcast.write;
            end else if (sweep_clear) begin
                used_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            used_reg  <= 1'b0;
            dirty_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (bcast.update && victim) begin
            page_reg  <= bcast.page;
            frame_reg <= bcast.walk;
        end
    end

endmodule

>>> design/tlb_lookup_clock_replace.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------------
// input     | s_valid / s_ready  | s_virtual_page, s_write_access, s_walk_frame
// result    | m_valid / m_ready  | m_frame, m_hit, m_slot, m_mark_page_dirty
// config    | cfg_wr_en          | cfg_wr_data (entries_in_use)
//
// Capture into the request register, then an update cycle in which the row of
// entry cells compares, picks the victim and updates; s_ready stays low meanwhile.
// The result register holds a finished item; the update cycle waits while it
// is still full and not taken, so a stalled result stalls at most one item.
// Synchronous active-low reset clears valid, used and dirty bits at once.
module tlb_lookup_clock_replace (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [tlbc_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tlbc_pkg::PAGE_W-1:0] s_virtual_page,
    input  logic                        s_write_access,
    input  logic [tlbc_pkg::PAGE_W-1:0] s_walk_frame,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tlbc_pkg::PAGE_W-1:0] m_frame,
    output logic                        m_hit,
    output logic [tlbc_pkg::SLOT_W-1:0] m_slot,
    output logic                        m_mark_page_dirty
);

    localparam int N = tlbc_pkg::TLB_ENTRIES;

    // configuration
    logic [tlbc_pkg::CFG_W-1:0] entries_reg;
    logic [tlbc_pkg::CMP_W-1:0] eff_count;

    // request register
    logic                        busy_reg;
    logic [tlbc_pkg::PAGE_W-1:0] q_page_reg;
    logic                        q_write_reg;
    logic [tlbc_pkg::PAGE_W-1:0] q_walk_reg;

    // result register
    logic                        m_valid_reg;
    logic [tlbc_pkg::PAGE_W-1:0] m_frame_reg;
    logic                        m_hit_reg;
    logic [tlbc_pkg::SLOT_W-1:0] m_slot_reg;
    logic                        m_dirty_reg;

    logic                  update;
    tlbc_pkg::tlbc_chain_t chain [0:N];
    tlbc_pkg::tlbc_res_t   res   [0:N-1];
    tlbc_pkg::tlbc_bcast_t bcast;
    logic [N-1:0]          active;

    logic [tlbc_pkg::PAGE_W-1:0] hit_frame;
    logic [tlbc_pkg::SLOT_W-1:0] sel_slot;

    // a count of zero acts as one; counts above the row are cut by the compare
    assign eff_count = (entries_reg == '0) ? tlbc_pkg::CMP_W'(1) :
                       tlbc_pkg::CMP_W'(entries_reg);

    // advance the request only when the result register is free
    assign update  = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready = !busy_reg;

    assign chain[0] = '{lead: 1'b1, hit_seen: 1'b0, inv_seen: 1'b0,
                        unused_seen: 1'b0};

    // outcome of the whole row, broadcast back to every cell
    assign bcast.update     = update;
    assign bcast.any_hit    = chain[N].hit_seen;
    assign bcast.any_inv    = chain[N].inv_seen;
    assign bcast.any_unused = chain[N].unused_seen;
    assign bcast.write      = q_write_reg;
    assign bcast.page       = q_page_reg;
    assign bcast.walk       = q_walk_reg;

    for (genvar k = 0; k < N; k++) begin : g_cell
        assign active[k] = tlbc_pkg::CMP_W'(k) < eff_count;

        tlbc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .active    (active[k]),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1]),
            .bcast     (bcast),
            .res       (res[k])
        );
    end

    // exactly one cell is selected; OR its frame and index together
    always_comb begin
        hit_frame = '0;
        sel_slot  = '0;
        for (int k = 0; k < N; k++) begin
            hit_frame = hit_frame | res[k].frame;
            if (res[k].sel) begin
                sel_slot = sel_slot | tlbc_pkg::SLOT_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= tlbc_pkg::ENTRIES_RESET;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                entries_reg <= cfg_wr_data;
            end
            // hold the request until its update cycle, then drop it
            if (s_valid && s_ready) begin
                busy_reg <= 1'b1;
            end else if (update) begin
                busy_reg <= 1'b0;
            end
            if (update) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            q_page_reg  <= s_virtual_page;
            q_write_reg <= s_write_access;
            q_walk_reg  <= s_walk_frame;
        end
        if (update) begin
            m_frame_reg <= chain[N].hit_seen ? hit_frame : q_walk_reg;
            m_hit_reg   <= chain[N].hit_seen;
            m_slot_reg  <= sel_slot;
            m_dirty_reg <= q_write_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_frame           = m_frame_reg;
    assign m_hit             = m_hit_reg;
    assign m_slot            = m_slot_reg;
    assign m_mark_page_dirty = m_dirty_reg;

endmodule

>>> verif/tlb_lookup_clock_replace_tb.sv
module tlb_lookup_clock_replace_tb;

    // Receiver hold-off used to fill the block and stall its input.
    localparam int HOLD_OFF_CYCLES = 80;

    // One translation as the result channel shows it.
    typedef struct packed {
        logic [tlbc_pkg::PAGE_W-1:0] frame;
        logic                        hit;
        logic [tlbc_pkg::SLOT_W-1:0] slot;
        logic                        mark_dirty;
    } translation_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [tlbc_pkg::CFG_W-1:0]  cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [tlbc_pkg::PAGE_W-1:0] s_virtual_page;
    logic                        s_write_access;
    logic [tlbc_pkg::PAGE_W-1:0] s_walk_frame;
    logic                        m_valid;
    logic                        m_ready;
    logic [tlbc_pkg::PAGE_W-1:0] m_frame;
    logic                        m_hit;
    logic [tlbc_pkg::SLOT_W-1:0] m_slot;
    logic                        m_mark_page_dirty;

    // Mirror of the TLB contents and of the active-entry register.
    logic                        tlb_valid [tlbc_pkg::TLB_ENTRIES];
    logic                        tlb_used  [tlbc_pkg::TLB_ENTRIES];
    logic                        tlb_dirty [tlbc_pkg::TLB_ENTRIES];
    logic [tlbc_pkg::PAGE_W-1:0] tlb_page  [tlbc_pkg::TLB_ENTRIES];
    logic [tlbc_pkg::PAGE_W-1:0] tlb_frame [tlbc_pkg::TLB_ENTRIES];
    logic [tlbc_pkg::CFG_W-1:0]  active_setting;

    translation_t pending_translations[$];
    int           mismatch_count;
    logic         quiet;          // no idling on either side while set
    logic         hold_off_req;   // ask the receiver for a long hold-off

    tlb_lookup_clock_replace DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_virtual_page    (s_virtual_page),
        .s_write_access    (s_write_access),
        .s_walk_frame      (s_walk_frame),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame           (m_frame),
        .m_hit             (m_hit),
        .m_slot            (m_slot),
        .m_mark_page_dirty (m_mark_page_dirty)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Clamp the register value to the range of entries actually present.
    function automatic int active_count_of(input logic [tlbc_pkg::CFG_W-1:0] setting);
        int n;
        n = int'(setting);
        if (n < 1) n = 1;
        if (n > tlbc_pkg::TLB_ENTRIES) n = tlbc_pkg::TLB_ENTRIES;
        return n;
    endfunction

    // Translate one page against the mirror and update it as the block must.
    function automatic translation_t predict_translation(
        input logic [tlbc_pkg::PAGE_W-1:0] page,
        input logic                        wr_access,
        input logic [tlbc_pkg::PAGE_W-1:0] walk);
        translation_t res;
        int           n;
        int           idx;
        int           victim;
        logic         found;
        logic         picked;
        n      = active_count_of(active_setting);
        found  = 1'b0;
        victim = 0;
        // lowest matching active entry wins
        for (idx = 0; idx < n; idx++) begin
            if (!found && tlb_valid[idx] && tlb_page[idx] == page) begin
                found  = 1'b1;
                victim = idx;
            end
        end
        if (found) begin
            res.frame       = tlb_frame[victim];
            tlb_used[victim] = 1'b1;
            if (wr_access) tlb_dirty[victim] = 1'b1;
        end else begin
            picked = 1'b0;
            // first invalid active entry, if any
            for (idx = 0; idx < n; idx++) begin
                if (!picked && !tlb_valid[idx]) begin
                    picked = 1'b1;
                    victim = idx;
                end
            end
            // clock sweep from entry 0, clearing used bits on the way
            for (idx = 0; idx < n; idx++) begin
                if (!picked) begin
                    if (!tlb_used[idx]) begin
                        picked = 1'b1;
                        victim = idx;
                    end else begin
                        tlb_used[idx] = 1'b0;
                    end
                end
            end
            if (!picked) victim = 0;
            res.frame         = walk;
            tlb_page[victim]  = page;
            tlb_frame[victim] = walk;
            tlb_valid[victim] = 1'b1;
            tlb_used[victim]  = 1'b1;
            tlb_dirty[victim] = wr_access;
        end
        res.hit        = found;
        res.slot       = tlbc_pkg::SLOT_W'(victim);
        res.mark_dirty = wr_access;
        return res;
    endfunction

    task automatic check_field(input string what,
                               input logic [tlbc_pkg::PAGE_W-1:0] want,
                               input logic [tlbc_pkg::PAGE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Compare every accepted result with the oldest pending translation.
    always @(posedge aclk) begin : result_check
        translation_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_translations.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual frame %h hit %b slot %0d",
                         $time, m_frame, m_hit, m_slot);
                mismatch_count++;
            end else begin
                want = pending_translations.pop_front();
                check_field("frame", want.frame, m_frame);
                check_field("hit", tlbc_pkg::PAGE_W'(want.hit), tlbc_pkg::PAGE_W'(m_hit));
                check_field("slot", tlbc_pkg::PAGE_W'(want.slot), tlbc_pkg::PAGE_W'(m_slot));
                check_field("mark_page_dirty", tlbc_pkg::PAGE_W'(want.mark_dirty),
                            tlbc_pkg::PAGE_W'(m_mark_page_dirty));
            end
        end
    end

    // Result side: random stalls, or one long hold-off on request.
    initial begin : receiver_side
        int held;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                // count the hold-off out cycle by cycle
                for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge aclk);
                hold_off_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < 6) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one item, hold it until taken, then record its translation.
    task automatic send_item(input logic [tlbc_pkg::PAGE_W-1:0] page,
                             input logic                        wr_access,
                             input logic [tlbc_pkg::PAGE_W-1:0] walk);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_virtual_page <= page;
        s_write_access <= wr_access;
        s_walk_frame   <= walk;
        do @(posedge aclk); while (!s_ready);
        pending_translations.push_back(predict_translation(page, wr_access, walk));
    endtask

    // Drop valid and let every pending translation come out.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_translations.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the active-entry register while the block is idle.
    task automatic set_active_entries(input logic [tlbc_pkg::CFG_W-1:0] setting);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        active_setting = setting;
    endtask

    task automatic apply_reset();
        int idx;
        for (idx = 0; idx < tlbc_pkg::TLB_ENTRIES; idx++) begin
            tlb_valid[idx] = 1'b0;
            tlb_used[idx]  = 1'b0;
            tlb_dirty[idx] = 1'b0;
            tlb_page[idx]  = '0;
            tlb_frame[idx] = '0;
        end
        active_setting = tlbc_pkg::ENTRIES_RESET;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    endtask

    // Extremes of page and frame; write hits must raise the dirty mark.
    task automatic test_field_extremes();
        send_item(20'h00000, 1'b0, 20'h00000);
        send_item(20'hFFFFF, 1'b1, 20'hFFFFF);
        send_item(20'h00000, 1'b1, 20'h12345);
        send_item(20'hFFFFF, 1'b0, 20'h00000);
        send_item(20'hAAAAA, 1'b1, 20'h55555);
        send_item(20'h55555, 1'b0, 20'hAAAAA);
    endtask

    // Two active entries, both used: the sweep clears both and entry 0 is refilled.
    task automatic test_clock_sweep();
        set_active_entries(tlbc_pkg::CFG_W'(2));
        send_item(20'h00100, 1'b0, 20'h0F100);
        send_item(20'h00101, 1'b1, 20'h0F101);
        send_item(20'h00100, 1'b0, 20'h00000);
        send_item(20'h00102, 1'b0, 20'h0F102);
    endtask

    // Pages parked in inactive entries miss, and later duplicates resolve low.
    task automatic test_inactive_and_duplicates();
        send_item(20'hAAAAA, 1'b0, 20'h0BEEF);
        set_active_entries(tlbc_pkg::CFG_W'(16));
        send_item(20'hAAAAA, 1'b1, 20'h00000);
        send_item(20'h55555, 1'b0, 20'h00000);
    endtask

    // Register values outside the entry range are clamped.
    task automatic test_active_saturation();
        set_active_entries(tlbc_pkg::CFG_W'(0));
        send_item(20'h00077, 1'b0, 20'h01077);
        send_item(20'h00078, 1'b1, 20'h01078);
        send_item(20'h00078, 1'b0, 20'h00000);
        set_active_entries(tlbc_pkg::CFG_W'(31));
        send_item(20'h00077, 1'b0, 20'h02077);
        set_active_entries(tlbc_pkg::CFG_W'(17));
        send_item(20'h00079, 1'b1, 20'h01079);
    endtask

    // Hold the result side off long enough for the input to stall.
    task automatic test_back_pressure();
        int cnt;
        set_active_entries(tlbc_pkg::CFG_W'(16));
        quiet        = 1'b1;
        hold_off_req = 1'b1;
        for (cnt = 0; cnt < 16; cnt++)
            send_item(tlbc_pkg::PAGE_W'($urandom_range(0, 7)), 1'($urandom),
                      tlbc_pkg::PAGE_W'($urandom));
        wait (hold_off_req == 1'b0);
        quiet = 1'b0;
    endtask

    // Mostly pages from a pool slightly larger than the active set, so hits,
    // refills and sweeps all occur; the rest are fresh random pages.
    task automatic run_random_phase(input logic [tlbc_pkg::CFG_W-1:0] setting,
                                    input int count, input logic no_idle);
        logic [tlbc_pkg::PAGE_W-1:0] page_pool [tlbc_pkg::TLB_ENTRIES + 6];
        logic [tlbc_pkg::PAGE_W-1:0] page;
        int                          pool_size;
        int                          cnt;
        set_active_entries(setting);
        pool_size = active_count_of(setting) + int'($urandom_range(1, 6));
        for (cnt = 0; cnt < pool_size; cnt++) page_pool[cnt] = tlbc_pkg::PAGE_W'($urandom);
        quiet = no_idle;
        for (cnt = 0; cnt < count; cnt++) begin
            if ($urandom_range(0, 99) < 85)
                page = page_pool[$urandom_range(0, pool_size - 1)];
            else
                page = tlbc_pkg::PAGE_W'($urandom);
            send_item(page, 1'($urandom), tlbc_pkg::PAGE_W'($urandom));
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(tlbc_pkg::CFG_W'(16), 45, 1'b0);
        run_random_phase(tlbc_pkg::CFG_W'(1), 35, 1'b0);
        run_random_phase(tlbc_pkg::CFG_W'(2), 35, 1'b0);
        run_random_phase(tlbc_pkg::CFG_W'(5), 40, 1'b0);
        run_random_phase(tlbc_pkg::CFG_W'(16), 50, 1'b1);
        run_random_phase(tlbc_pkg::CFG_W'(8), 40, 1'b0);
        run_random_phase(tlbc_pkg::CFG_W'(31), 40, 1'b0);
        run_random_phase(tlbc_pkg::CFG_W'(0), 25, 1'b0);
        run_random_phase(tlbc_pkg::CFG_W'(12), 40, 1'b0);
        run_random_phase(tlbc_pkg::CFG_W'($urandom_range(0, 31)), 40, 1'b0);
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_virtual_page = '0;
        s_write_access = 1'b0;
        s_walk_frame   = '0;
        quiet          = 1'b0;
        hold_off_req   = 1'b0;
        mismatch_count = 0;

        apply_reset();
        test_field_extremes();
        test_clock_sweep();
        test_inactive_and_duplicates();
        test_active_saturation();
        test_back_pressure();
        test_random_traffic();

        // drain, then allow the pipeline a few more cycles
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_translations.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
